// ----- rtl/ffdo_pkg.sv -----
package ffdo_pkg;

  localparam int SLOTS           = 16;
  localparam int MAX_FRAME_BYTES = 64;
  localparam int RING_SLOTS      = SLOTS + 1;

  localparam int SLOT_W     = 5;
  localparam int CNT_W      = 5;
  localparam int LEN_W      = 7;
  localparam int BYTE_DEPTH = RING_SLOTS * MAX_FRAME_BYTES;
  localparam int BYTE_AW    = $clog2(BYTE_DEPTH);
  localparam int META_AW    = $clog2(RING_SLOTS);
  localparam int META_W     = LEN_W + 64;

  typedef enum logic [2:0] {
    STAT_POP_BYTE  = 3'd0,
    STAT_COMMITTED = 3'd1,
    STAT_TOO_LONG  = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_SHORT     = 3'd4
  } status_e;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_e;

endpackage

// ----- rtl/ffdo_ram.sv -----
module ffdo_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/frame_fifo_drop_oldest.sv -----
// Channel     Direction  Handshake                Payload
// s_axis      in         s_axis_tvalid/tready     tdata, tuser = opcode, tlast = frame_end
// m_axis      out        m_axis_tvalid/tready     tdata, tuser = status, tlast = out_last
// cfg         in         cfg_we_i (no wait)       cfg_data_i = slot_count
//
// Push items stream at one item per cycle while idle with a free output stage.
// A pop with bytes to give is accepted in idle, reads its metadata, reads the
// first byte, streams the bytes of the frame and then returns to idle.
// An empty pop is answered from idle and a short pop from the metadata state.
// Reset clears the ring and statistics; no memory clearing pass is needed.
// A stalled output holds its item; the input stalls while a pop streams.
module frame_fifo_drop_oldest (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // data_byte[7:0], frame_sequence[39:8], frame_time_ms[71:40], pop_limit[78:72]
  input  logic [79:0]   s_axis_tdata,
  // opcode
  input  logic          s_axis_tuser,
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_byte[7:0], out_length[14:8], out_sequence[46:15], out_time_ms[78:47],
  // depth[83:79], peak_depth[88:84], drop_total[120:89]
  output logic [127:0]  m_axis_tdata,
  // status
  output logic [2:0]    m_axis_tuser,
  output logic          m_axis_tlast,
  input  logic          cfg_we_i,
  input  logic [4:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_META   = 3'b010,
    ST_STREAM = 3'b100
  } state_e;

  localparam int LW = ffdo_pkg::LEN_W;
  localparam int SW = ffdo_pkg::SLOT_W;
  localparam int CW = ffdo_pkg::CNT_W;

  state_e state_q, state_d;

  logic [CW-1:0] slot_cnt_q, slot_cnt_d;
  logic [SW-1:0] wslot_q, wslot_d;
  logic [SW-1:0] rslot_q, rslot_d;
  logic [SW-1:0] pslot_q, pslot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] peak_q, peak_d;
  logic [31:0]   drop_q, drop_d;
  logic [LW-1:0] bw_q, bw_d;
  logic          too_long_q, too_long_d;

  logic [LW-1:0] limit_q, limit_d;
  logic [LW-1:0] len_q, len_d;
  logic [31:0]   seq_q, seq_d;
  logic [31:0]   tm_q, tm_d;
  logic [LW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_pend_q, rd_pend_d;
  logic          pend_last_q, pend_last_d;

  logic                      out_vld_q, out_vld_d;
  ffdo_pkg::status_e         out_stat_q, out_stat_d;
  logic [7:0]                out_byte_q, out_byte_d;
  logic [LW-1:0]             out_len_q, out_len_d;
  logic                      out_last_q, out_last_d;
  logic [31:0]               out_seq_q, out_seq_d;
  logic [31:0]               out_tm_q, out_tm_d;

  logic          out_free, in_acc, is_push, is_pop;
  logic [7:0]    in_byte;
  logic [31:0]   in_seq, in_tm;
  logic [LW-1:0] in_limit;
  logic          overlong, ring_full;
  logic [LW-1:0] commit_len;
  logic [LW-1:0] meta_len, meta_len_sat;
  logic [31:0]   meta_seq, meta_tm;
  logic          move, issue;

  logic                            byte_we, byte_re;
  logic [ffdo_pkg::BYTE_AW-1:0]    byte_waddr, byte_raddr;
  logic [7:0]                      byte_rdata;
  logic                            meta_we, meta_re;
  logic [ffdo_pkg::META_AW-1:0]    meta_waddr, meta_raddr;
  logic [ffdo_pkg::META_W-1:0]     meta_wdata, meta_rdata;

  function automatic logic [SW-1:0] next_slot(logic [SW-1:0] s, logic [CW-1:0] n);
    return (s == SW'(n)) ? '0 : s + SW'(1);
  endfunction

  assign in_byte  = s_axis_tdata[7:0];
  assign in_seq   = s_axis_tdata[39:8];
  assign in_tm    = s_axis_tdata[71:40];
  assign in_limit = s_axis_tdata[78:72];

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_push       = in_acc && (s_axis_tuser == ffdo_pkg::OP_PUSH);
  assign is_pop        = in_acc && (s_axis_tuser == ffdo_pkg::OP_POP);

  // A frame is overlong once a byte arrives with the slot already full.
  assign overlong   = too_long_q || (bw_q >= LW'(ffdo_pkg::MAX_FRAME_BYTES));
  assign commit_len = bw_q + LW'(1);
  assign ring_full  = cnt_q >= slot_cnt_q;

  assign byte_we    = is_push && (bw_q < LW'(ffdo_pkg::MAX_FRAME_BYTES));
  assign byte_waddr = ffdo_pkg::BYTE_AW'(32'(wslot_q) * ffdo_pkg::MAX_FRAME_BYTES
                                         + 32'(bw_q));
  assign meta_we    = is_push && s_axis_tlast && !overlong;
  assign meta_waddr = ffdo_pkg::META_AW'(wslot_q);
  assign meta_wdata = {commit_len, in_seq, in_tm};
  assign meta_re    = is_pop && (cnt_q != '0);
  assign meta_raddr = ffdo_pkg::META_AW'(rslot_q);

  assign meta_len     = meta_rdata[ffdo_pkg::META_W-1 -: LW];
  assign meta_seq     = meta_rdata[63:32];
  assign meta_tm      = meta_rdata[31:0];
  assign meta_len_sat = (meta_len > LW'(ffdo_pkg::MAX_FRAME_BYTES))
                      ? LW'(ffdo_pkg::MAX_FRAME_BYTES) : meta_len;

  // The byte memory output register holds one byte until the output stage
  // takes it; reads go out at one per cycle while the output stage is free.
  assign move       = (state_q == ST_STREAM) && rd_pend_q && out_free;
  assign issue      = (state_q == ST_STREAM) && (rd_idx_q < len_q) && (!rd_pend_q || move);
  assign byte_re    = issue;
  assign byte_raddr = ffdo_pkg::BYTE_AW'(32'(pslot_q) * ffdo_pkg::MAX_FRAME_BYTES
                                         + 32'(rd_idx_q));

  ffdo_ram #(
    .Width (8),
    .Depth (ffdo_pkg::BYTE_DEPTH)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (in_byte),
    .re_i    (byte_re),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  ffdo_ram #(
    .Width (ffdo_pkg::META_W),
    .Depth (ffdo_pkg::RING_SLOTS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  always_comb begin
    state_d     = state_q;
    slot_cnt_d  = slot_cnt_q;
    wslot_d     = wslot_q;
    rslot_d     = rslot_q;
    pslot_d     = pslot_q;
    cnt_d       = cnt_q;
    peak_d      = peak_q;
    drop_d      = drop_q;
    bw_d        = bw_q;
    too_long_d  = too_long_q;
    limit_d     = limit_q;
    len_d       = len_q;
    seq_d       = seq_q;
    tm_d        = tm_q;
    rd_idx_d    = rd_idx_q;
    rd_pend_d   = rd_pend_q;
    pend_last_d = pend_last_q;

    out_vld_d  = out_vld_q && !m_axis_tready;
    out_stat_d = out_stat_q;
    out_byte_d = out_byte_q;
    out_len_d  = out_len_q;
    out_last_d = out_last_q;
    out_seq_d  = out_seq_q;
    out_tm_d   = out_tm_q;

    case (state_q)
      ST_IDLE: begin
        if (is_push) begin
          if (bw_q < LW'(ffdo_pkg::MAX_FRAME_BYTES)) begin
            bw_d = commit_len;
          end else begin
            too_long_d = 1'b1;
          end
          if (s_axis_tlast) begin
            bw_d       = '0;
            too_long_d = 1'b0;
            out_vld_d  = 1'b1;
            out_byte_d = '0;
            out_last_d = 1'b1;
            if (overlong) begin
              out_stat_d = ffdo_pkg::STAT_TOO_LONG;
              out_len_d  = '0;
              out_seq_d  = '0;
              out_tm_d   = '0;
            end else begin
              out_stat_d = ffdo_pkg::STAT_COMMITTED;
              out_len_d  = commit_len;
              out_seq_d  = in_seq;
              out_tm_d   = in_tm;
              wslot_d    = next_slot(wslot_q, slot_cnt_q);
              if (ring_full) begin
                // Make room by retiring the oldest frame.
                rslot_d = next_slot(rslot_q, slot_cnt_q);
                drop_d  = drop_q + 32'd1;
              end else begin
                cnt_d = cnt_q + CW'(1);
                if (cnt_q + CW'(1) > peak_q) begin
                  peak_d = cnt_q + CW'(1);
                end
              end
            end
          end
        end else if (is_pop) begin
          if (cnt_q == '0) begin
            out_vld_d  = 1'b1;
            out_stat_d = ffdo_pkg::STAT_EMPTY;
            out_byte_d = '0;
            out_len_d  = '0;
            out_last_d = 1'b1;
            out_seq_d  = '0;
            out_tm_d   = '0;
          end else begin
            limit_d = in_limit;
            state_d = ST_META;
          end
        end
      end
      ST_META: begin
        // Wait for a free output stage so a pending result keeps its depth.
        if (out_free) begin
          if (meta_len_sat > limit_q) begin
            out_vld_d  = 1'b1;
            out_stat_d = ffdo_pkg::STAT_SHORT;
            out_byte_d = '0;
            out_len_d  = meta_len_sat;
            out_last_d = 1'b1;
            out_seq_d  = '0;
            out_tm_d   = '0;
            state_d    = ST_IDLE;
          end else begin
            len_d     = meta_len_sat;
            seq_d     = meta_seq;
            tm_d      = meta_tm;
            pslot_d   = rslot_q;
            rslot_d   = next_slot(rslot_q, slot_cnt_q);
            cnt_d     = cnt_q - CW'(1);
            rd_idx_d  = '0;
            rd_pend_d = 1'b0;
            state_d   = ST_STREAM;
          end
        end
      end
      ST_STREAM: begin
        if (move) begin
          out_vld_d  = 1'b1;
          out_stat_d = ffdo_pkg::STAT_POP_BYTE;
          out_byte_d = byte_rdata;
          out_len_d  = len_q;
          out_last_d = pend_last_q;
          out_seq_d  = seq_q;
          out_tm_d   = tm_q;
        end
        if (issue) begin
          rd_idx_d    = rd_idx_q + LW'(1);
          rd_pend_d   = 1'b1;
          pend_last_d = (rd_idx_q == len_q - LW'(1));
        end else if (move) begin
          rd_pend_d = 1'b0;
        end
        if ((rd_idx_q == len_q) && !rd_pend_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A register write sets the ring up anew.
    if (cfg_we_i) begin
      if (cfg_data_i == '0) begin
        slot_cnt_d = CW'(1);
      end else if (cfg_data_i > CW'(ffdo_pkg::SLOTS)) begin
        slot_cnt_d = CW'(ffdo_pkg::SLOTS);
      end else begin
        slot_cnt_d = cfg_data_i;
      end
      wslot_d    = '0;
      rslot_d    = '0;
      cnt_d      = '0;
      peak_d     = '0;
      drop_d     = '0;
      bw_d       = '0;
      too_long_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_cnt_q  <= CW'(ffdo_pkg::SLOTS);
      wslot_q     <= '0;
      rslot_q     <= '0;
      cnt_q       <= '0;
      peak_q      <= '0;
      drop_q      <= '0;
      bw_q        <= '0;
      too_long_q  <= 1'b0;
      rd_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_cnt_q  <= slot_cnt_d;
      wslot_q     <= wslot_d;
      rslot_q     <= rslot_d;
      cnt_q       <= cnt_d;
      peak_q      <= peak_d;
      drop_q      <= drop_d;
      bw_q        <= bw_d;
      too_long_q  <= too_long_d;
      rd_idx_q    <= rd_idx_d;
      rd_pend_q   <= rd_pend_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pslot_q     <= pslot_d;
    limit_q     <= limit_d;
    len_q       <= len_d;
    seq_q       <= seq_d;
    tm_q        <= tm_d;
    pend_last_q <= pend_last_d;
    out_stat_q  <= out_stat_d;
    out_byte_q  <= out_byte_d;
    out_len_q   <= out_len_d;
    out_last_q  <= out_last_d;
    out_seq_q   <= out_seq_d;
    out_tm_q    <= out_tm_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, drop_q, peak_q, cnt_q, out_tm_q, out_seq_q,
                          out_len_q, out_byte_q};

  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= slot_cnt_q)
    else $error("frame count exceeds ring capacity");

  a_peak_covers_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= cnt_q)
    else $error("peak depth below current depth");

  a_ready_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == ST_IDLE))
    else $error("input accepted while a pop is in progress");

  a_stream_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STREAM) |-> (rd_idx_q <= len_q))
    else $error("byte read index ran past the frame length");

  a_pop_reads_meta : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_META) |-> $past(meta_re))
    else $error("metadata state entered without a metadata read");

endmodule
